// ----- rtl/core/htw_pkg.sv -----
// Package for the hierarchical timing wheel: opcode, event and ALU operation codes,
// link encoding and field widths. No dependencies.
package htw_pkg;

   localparam int SLOT_W   = 6;
   localparam int SLOTS    = 64;
   localparam int HANDLE_W = 6;
   localparam int LINK_W   = 7;
   localparam int LEN_W    = 24;
   localparam int TIME_W   = 32;

   // Link value that marks the end of a list.
   localparam logic [LINK_W-1:0] NIL = 7'h7F;

   typedef enum logic [1:0] {
      OP_TICK     = 2'd0,
      OP_ONESHOT  = 2'd1,
      OP_PERIODIC = 2'd2,
      OP_CANCEL   = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      EV_STARTED   = 3'd0,
      EV_EXPIRED   = 3'd1,
      EV_CANCELED  = 3'd2,
      EV_NOT_FOUND = 3'd3,
      EV_BAD_LEN   = 3'd4,
      EV_FULL      = 3'd5
   } event_kind_type;

   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

endpackage

// ----- rtl/core/htw_alu.sv -----
// Shared 32-bit add/subtract unit of the timing wheel sequencer.
// Depends on htw_pkg for the operation code.
module htw_alu import htw_pkg::*; (
   input  alu_op_type        alu_op,
   input  logic [TIME_W-1:0] opa,
   input  logic [TIME_W-1:0] opb,
   output logic [TIME_W-1:0] result
);

   logic [TIME_W-1:0] opb_x;

   // One adder; subtraction inverts the second operand and adds one.
   always_comb begin
      opb_x  = (alu_op == ALU_SUB) ? ~opb : opb;
      result = TIME_W'(opa + opb_x + TIME_W'(alu_op == ALU_SUB));
   end

endmodule

// ----- rtl/core/hierarchical_timing_wheel_unit.sv -----
// Hierarchical timing wheel: LEVELS wheels of 64 slots, TIMERS timers in linked slot lists.
// Depends on htw_pkg and htw_alu.
// A start scans for the lowest free handle, one handle scanned per cycle; a tick advances
// the wheels, re-files the timers of each wrapped level, then reports the level 0 expiries.
// One item at a time; busy is high while an item is worked. Results cannot be stalled.
// Synchronous reset, then a clearing pass over all LEVELS*64 slot list memory entries.
module hierarchical_timing_wheel_unit import htw_pkg::*; #(
   parameter int LEVELS = 4,
   parameter int TIMERS = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_opcode,
   input  logic [LEN_W-1:0]    req_length_ms,
   input  logic [HANDLE_W-1:0] req_cancel_handle,
   output logic                rsp_valid,
   output logic [2:0]          rsp_event_kind,
   output logic [HANDLE_W-1:0] rsp_timer_handle,
   output logic                rsp_last_event
);

   localparam int HW        = (TIMERS > 1) ? $clog2(TIMERS) : 1;
   localparam int LVW       = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int BW        = LVW + SLOT_W;
   localparam int NBKT      = LEVELS * SLOTS;
   localparam int SPAN_BITS = SLOT_W * LEVELS;
   localparam logic [63:0] SPAN64 = (64'd1 << SPAN_BITS) - 64'd1;
   localparam logic [LINK_W-1:0] TMAX = LINK_W'(TIMERS);

   typedef enum logic [19:0] {
      S_CLEAR   = 20'b00000000000000000001,
      S_IDLE    = 20'b00000000000000000010,
      S_SCAN    = 20'b00000000000000000100,
      S_NEW     = 20'b00000000000000001000,
      S_F_SUB   = 20'b00000000000000010000,
      S_F_LVL   = 20'b00000000000000100000,
      S_A_LINK  = 20'b00000000000001000000,
      S_A_TAIL  = 20'b00000000000010000000,
      S_TICK    = 20'b00000000000100000000,
      S_CHK     = 20'b00000000001000000000,
      S_ADV     = 20'b00000000010000000000,
      S_DET     = 20'b00000000100000000000,
      S_WALK    = 20'b00000001000000000000,
      S_WALK_RD = 20'b00000010000000000000,
      S_EXP_ISS = 20'b00000100000000000000,
      S_EXP_DET = 20'b00001000000000000000,
      S_EXP     = 20'b00010000000000000000,
      S_EXP_RD  = 20'b00100000000000000000,
      S_CAN_RD  = 20'b01000000000000000000,
      S_CAN_FIX = 20'b10000000000000000000
   } state_type;

   typedef enum logic [1:0] {
      CTX_START = 2'd0,
      CTX_CASC  = 2'd1,
      CTX_EXP   = 2'd2
   } ctx_type;

   // Control and working registers.
   state_type            state_ff, state_in;
   ctx_type              ctx_ff, ctx_in;
   logic                 per_ff, per_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic [LINK_W-1:0]    cur_ff, cur_in;
   logic [LINK_W-1:0]    nx_ff, nx_in;
   logic [LINK_W-1:0]    tl_ff, tl_in;
   logic [LINK_W-1:0]    rp_ff, rp_in;
   logic [LINK_W-1:0]    rn_ff, rn_in;
   logic [BW-1:0]        rb_ff, rb_in;
   logic [TIME_W-1:0]    dl_ff, dl_in;
   logic [TIME_W-1:0]    ms_ff, ms_in;
   logic [TIME_W-1:0]    ms_now_ff, ms_now_in;
   logic [LVW-1:0]       lvl_ff, lvl_in;
   logic [BW-1:0]        bidx_ff, bidx_in;
   logic [TIMERS-1:0]    active_ff, active_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   event_kind_type       rsp_kind_ff, rsp_kind_in;
   logic [HANDLE_W-1:0]  rsp_handle_ff, rsp_handle_in;
   logic                 rsp_last_ff, rsp_last_in;

   // Wheel positions: one index per cycle, shared by the read and the write.
   logic [SLOT_W-1:0]    pos_ff [LEVELS];
   logic [LVW-1:0]       pos_sel;
   logic [SLOT_W-1:0]    pos_rd;
   logic                 pos_we;
   logic [SLOT_W-1:0]    pos_wd;

   // Timer table memories, read together at one address.
   logic                 per_mem    [TIMERS];
   logic [LEN_W-1:0]     period_mem [TIMERS];
   logic [TIME_W-1:0]    dl_mem     [TIMERS];
   logic [BW-1:0]        bof_mem    [TIMERS];
   logic [LINK_W-1:0]    next_mem   [TIMERS];
   logic [LINK_W-1:0]    prev_mem   [TIMERS];
   logic [HW-1:0]        tmr_raddr;
   logic                 per_rd_ff;
   logic [LEN_W-1:0]     period_rd_ff;
   logic [TIME_W-1:0]    dl_rd_ff;
   logic [BW-1:0]        bof_rd_ff;
   logic [LINK_W-1:0]    next_rd_ff;
   logic [LINK_W-1:0]    prev_rd_ff;
   logic                 tmr_we;
   logic [HW-1:0]        tmr_waddr;
   logic                 dl_we;
   logic [HW-1:0]        dl_waddr;
   logic                 link_we;
   logic                 next_we;
   logic [HW-1:0]        next_waddr;
   logic [LINK_W-1:0]    next_wd;
   logic                 prev_we;
   logic [HW-1:0]        prev_waddr;
   logic [LINK_W-1:0]    prev_wd;

   // Slot list memory: head and tail of each slot.
   logic [2*LINK_W-1:0]  bkt_mem [NBKT];
   logic [BW-1:0]        bkt_raddr;
   logic [LINK_W-1:0]    head_rd_ff;
   logic [LINK_W-1:0]    tail_rd_ff;
   logic                 bkt_we;
   logic [BW-1:0]        bkt_waddr;
   logic [2*LINK_W-1:0]  bkt_wd;

   // Shared arithmetic unit.
   alu_op_type           alu_op;
   logic [TIME_W-1:0]    alu_a;
   logic [TIME_W-1:0]    alu_b;
   logic [TIME_W-1:0]    alu_y;

   // Placement and request decode.
   logic [TIME_W-1:0]    ms_c;
   logic [TIME_W-1:0]    ms_sh;
   logic [LVW-1:0]       place_lv;
   logic [SLOT_W-1:0]    place_s;
   logic [SLOT_W-1:0]    place_slot;
   logic [TIME_W-1:0]    req_len_c;
   logic                 tl_valid;
   logic                 do_ret;

   function automatic logic [TIME_W-1:0] clamp_span(input logic [TIME_W-1:0] x);
      logic [TIME_W-1:0] hi;
      begin
         hi = x >> SPAN_BITS;
         clamp_span = (hi != '0) ? SPAN64[TIME_W-1:0] : x;
      end
   endfunction

   function automatic logic link_ok(input logic [LINK_W-1:0] l);
      link_ok = (l < TMAX);
   endfunction

   htw_alu u_alu (
      .alu_op (alu_op),
      .opa    (alu_a),
      .opb    (alu_b),
      .result (alu_y)
   );

   assign pos_rd           = pos_ff[pos_sel];
   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_kind   = rsp_kind_ff;
   assign rsp_timer_handle = rsp_handle_ff;
   assign rsp_last_event   = rsp_last_ff;
   assign tl_valid         = link_ok(tail_rd_ff);

   // Requested length: zero becomes one, then saturate to the wheel span.
   assign req_len_c = clamp_span((req_length_ms == '0) ? TIME_W'(1) : TIME_W'(req_length_ms));

   // Placement of a timer: highest level with a nonzero digit, from the registered distance.
   always_comb begin
      ms_c     = clamp_span(ms_ff[TIME_W-1] ? '0 : ms_ff);
      place_lv = '0;
      place_s  = '0;
      ms_sh    = '0;
      for (int i = 1; i < LEVELS; i++) begin
         ms_sh = ms_c >> (SLOT_W * i);
         if (ms_sh != '0) begin
            place_lv = LVW'(i);
            place_s  = ms_sh[SLOT_W-1:0];
         end
      end
      if (place_lv == '0) begin
         place_slot = SLOT_W'(pos_rd + ms_c[SLOT_W-1:0]);
      end else begin
         place_slot = SLOT_W'(pos_rd + place_s - SLOT_W'(1));
      end
   end

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      ctx_in        = ctx_ff;
      per_in        = per_ff;
      len_in        = len_ff;
      cur_in        = cur_ff;
      nx_in         = nx_ff;
      tl_in         = tl_ff;
      rp_in         = rp_ff;
      rn_in         = rn_ff;
      rb_in         = rb_ff;
      dl_in         = dl_ff;
      ms_in         = ms_ff;
      ms_now_in     = ms_now_ff;
      lvl_in        = lvl_ff;
      bidx_in       = bidx_ff;
      active_in     = active_ff;
      rsp_valid_in  = 1'b0;
      rsp_kind_in   = rsp_kind_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_last_in   = rsp_last_ff;
      pos_sel       = '0;
      pos_we        = 1'b0;
      pos_wd        = SLOT_W'(pos_rd + SLOT_W'(1));
      tmr_raddr     = cur_ff[HW-1:0];
      tmr_we        = 1'b0;
      tmr_waddr     = cur_ff[HW-1:0];
      dl_we         = 1'b0;
      dl_waddr      = cur_ff[HW-1:0];
      link_we       = 1'b0;
      next_we       = 1'b0;
      next_waddr    = cur_ff[HW-1:0];
      next_wd       = NIL;
      prev_we       = 1'b0;
      prev_waddr    = cur_ff[HW-1:0];
      prev_wd       = tail_rd_ff;
      bkt_raddr     = bidx_ff;
      bkt_we        = 1'b0;
      bkt_waddr     = bidx_ff;
      bkt_wd        = {NIL, NIL};
      alu_op        = ALU_ADD;
      alu_a         = ms_now_ff;
      alu_b         = TIME_W'(1);
      do_ret        = 1'b0;

      case (state_ff)
         // Sweep the slot list memory empty after reset.
         S_CLEAR: begin
            bkt_we = 1'b1;
            if (bidx_ff == BW'(NBKT - 1)) begin
               state_in = S_IDLE;
            end else begin
               bidx_in = BW'(bidx_ff + BW'(1));
            end
         end

         // Take a request transfer and dispatch it.
         S_IDLE: begin
            tmr_raddr = req_cancel_handle[HW-1:0];
            if (start) begin
               cur_in = LINK_W'(req_cancel_handle);
               case (req_opcode)
                  OP_TICK: begin
                     state_in = S_TICK;
                  end
                  OP_CANCEL: begin
                     if ((32'(req_cancel_handle) >= TIMERS) ||
                         !active_ff[req_cancel_handle[HW-1:0]]) begin
                        rsp_valid_in  = 1'b1;
                        rsp_kind_in   = EV_NOT_FOUND;
                        rsp_handle_in = req_cancel_handle;
                        rsp_last_in   = 1'b1;
                     end else begin
                        state_in = S_CAN_RD;
                     end
                  end
                  default: begin
                     if ((req_opcode == OP_PERIODIC) && (req_length_ms == '0)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_kind_in   = EV_BAD_LEN;
                        rsp_handle_in = '0;
                        rsp_last_in   = 1'b1;
                     end else begin
                        len_in   = req_len_c[LEN_W-1:0];
                        per_in   = (req_opcode == OP_PERIODIC);
                        cur_in   = '0;
                        state_in = S_SCAN;
                     end
                  end
               endcase
            end
         end

         // Look for the lowest free handle, one per cycle.
         S_SCAN: begin
            if (!active_ff[cur_ff[HW-1:0]]) begin
               state_in = S_NEW;
            end else if (cur_ff[HANDLE_W-1:0] == HANDLE_W'(TIMERS - 1)) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = EV_FULL;
               rsp_handle_in = '0;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end else begin
               cur_in = LINK_W'(cur_ff + LINK_W'(1));
            end
         end

         // Fill in the new timer and compute its deadline.
         S_NEW: begin
            alu_b                   = TIME_W'(len_ff);
            active_in[cur_ff[HW-1:0]] = 1'b1;
            tmr_we                  = 1'b1;
            dl_we                   = 1'b1;
            dl_in                   = alu_y;
            ctx_in                  = CTX_START;
            state_in                = S_F_SUB;
         end

         // Distance from now to the deadline.
         S_F_SUB: begin
            alu_op   = ALU_SUB;
            alu_a    = dl_ff;
            alu_b    = ms_now_ff;
            ms_in    = alu_y;
            state_in = S_F_LVL;
         end

         // Pick the slot and read its list ends.
         S_F_LVL: begin
            pos_sel   = place_lv;
            bidx_in   = {place_lv, place_slot};
            bkt_raddr = {place_lv, place_slot};
            state_in  = S_A_LINK;
         end

         // Append the timer at the tail of the slot list.
         S_A_LINK: begin
            link_we = 1'b1;
            next_we = 1'b1;
            prev_we = 1'b1;
            bkt_we  = 1'b1;
            bkt_wd  = {(tl_valid ? head_rd_ff : cur_ff), cur_ff};
            tl_in   = tail_rd_ff;
            if (tl_valid) begin
               state_in = S_A_TAIL;
            end else begin
               do_ret = 1'b1;
            end
         end

         // Link the old tail forward to the new timer.
         S_A_TAIL: begin
            next_we    = 1'b1;
            next_waddr = tl_ff[HW-1:0];
            next_wd    = cur_ff;
            do_ret     = 1'b1;
         end

         // Advance the millisecond counter and the level 0 wheel.
         S_TICK: begin
            ms_now_in = alu_y;
            pos_we    = 1'b1;
            lvl_in    = '0;
            state_in  = S_CHK;
         end

         // A wheel that wrapped makes the next level advance and cascade.
         S_CHK: begin
            pos_sel = lvl_ff;
            if ((32'(lvl_ff) + 1 < LEVELS) && (pos_rd == '0)) begin
               state_in = S_ADV;
            end else begin
               state_in = S_EXP_ISS;
            end
         end

         S_ADV: begin
            pos_sel   = LVW'(lvl_ff + LVW'(1));
            pos_we    = 1'b1;
            bkt_raddr = {LVW'(lvl_ff + LVW'(1)), pos_rd};
            bidx_in   = {LVW'(lvl_ff + LVW'(1)), pos_rd};
            state_in  = S_DET;
         end

         S_DET: begin
            cur_in   = head_rd_ff;
            bkt_we   = 1'b1;
            state_in = S_WALK;
         end

         // Walk the detached list and re-file each timer.
         S_WALK: begin
            if (link_ok(cur_ff)) begin
               state_in = S_WALK_RD;
            end else begin
               lvl_in   = LVW'(lvl_ff + LVW'(1));
               state_in = S_CHK;
            end
         end

         S_WALK_RD: begin
            nx_in    = next_rd_ff;
            dl_in    = dl_rd_ff;
            ctx_in   = CTX_CASC;
            state_in = S_F_SUB;
         end

         // Detach the current level 0 slot.
         S_EXP_ISS: begin
            pos_sel   = '0;
            bkt_raddr = {LVW'(0), pos_rd};
            bidx_in   = {LVW'(0), pos_rd};
            state_in  = S_EXP_DET;
         end

         S_EXP_DET: begin
            cur_in   = head_rd_ff;
            bkt_we   = 1'b1;
            state_in = S_EXP;
         end

         S_EXP: begin
            if (link_ok(cur_ff)) begin
               state_in = S_EXP_RD;
            end else begin
               state_in = S_IDLE;
            end
         end

         // Report one expiry; periodic timers go back one period later.
         S_EXP_RD: begin
            rsp_valid_in  = 1'b1;
            rsp_kind_in   = EV_EXPIRED;
            rsp_handle_in = cur_ff[HANDLE_W-1:0];
            rsp_last_in   = !link_ok(next_rd_ff);
            nx_in         = next_rd_ff;
            alu_b         = TIME_W'(period_rd_ff);
            if (per_rd_ff) begin
               dl_in    = alu_y;
               dl_we    = 1'b1;
               ctx_in   = CTX_EXP;
               state_in = S_F_SUB;
            end else begin
               active_in[cur_ff[HW-1:0]] = 1'b0;
               cur_in   = next_rd_ff;
               state_in = S_EXP;
            end
         end

         // Cancel: read the neighbors, then unlink.
         S_CAN_RD: begin
            rb_in     = bof_rd_ff;
            rp_in     = prev_rd_ff;
            rn_in     = next_rd_ff;
            bkt_raddr = bof_rd_ff;
            state_in  = S_CAN_FIX;
         end

         S_CAN_FIX: begin
            bkt_we     = 1'b1;
            bkt_waddr  = rb_ff;
            bkt_wd     = {(link_ok(rp_ff) ? head_rd_ff : rn_ff),
                          (link_ok(rn_ff) ? tail_rd_ff : rp_ff)};
            next_we    = link_ok(rp_ff);
            next_waddr = rp_ff[HW-1:0];
            next_wd    = rn_ff;
            prev_we    = link_ok(rn_ff);
            prev_waddr = rn_ff[HW-1:0];
            prev_wd    = rp_ff;
            active_in[cur_ff[HW-1:0]] = 1'b0;
            rsp_valid_in  = 1'b1;
            rsp_kind_in   = EV_CANCELED;
            rsp_handle_in = cur_ff[HANDLE_W-1:0];
            rsp_last_in   = 1'b1;
            state_in      = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Return from filing to the operation that asked for it.
      if (do_ret) begin
         case (ctx_ff)
            CTX_START: begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = EV_STARTED;
               rsp_handle_in = cur_ff[HANDLE_W-1:0];
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
            CTX_CASC: begin
               cur_in   = nx_ff;
               state_in = S_WALK;
            end
            default: begin
               cur_in   = nx_ff;
               state_in = S_EXP;
            end
         endcase
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         bidx_ff      <= '0;
         active_ff    <= '0;
         ms_now_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < LEVELS; i++) begin
            pos_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         bidx_ff      <= bidx_in;
         active_ff    <= active_in;
         ms_now_ff    <= ms_now_in;
         rsp_valid_ff <= rsp_valid_in;
         if (pos_we) begin
            pos_ff[pos_sel] <= pos_wd;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      ctx_ff        <= ctx_in;
      per_ff        <= per_in;
      len_ff        <= len_in;
      cur_ff        <= cur_in;
      nx_ff         <= nx_in;
      tl_ff         <= tl_in;
      rp_ff         <= rp_in;
      rn_ff         <= rn_in;
      rb_ff         <= rb_in;
      dl_ff         <= dl_in;
      ms_ff         <= ms_in;
      lvl_ff        <= lvl_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Timer table memories.
   always_ff @(posedge clock) begin
      per_rd_ff    <= per_mem[tmr_raddr];
      period_rd_ff <= period_mem[tmr_raddr];
      dl_rd_ff     <= dl_mem[tmr_raddr];
      bof_rd_ff    <= bof_mem[tmr_raddr];
      next_rd_ff   <= next_mem[tmr_raddr];
      prev_rd_ff   <= prev_mem[tmr_raddr];
      if (tmr_we) begin
         per_mem[tmr_waddr]    <= per_ff;
         period_mem[tmr_waddr] <= len_ff;
      end
      if (dl_we) begin
         dl_mem[dl_waddr] <= alu_y;
      end
      if (link_we) begin
         bof_mem[cur_ff[HW-1:0]] <= bidx_ff;
      end
      if (next_we) begin
         next_mem[next_waddr] <= next_wd;
      end
      if (prev_we) begin
         prev_mem[prev_waddr] <= prev_wd;
      end
   end

   // Slot list memory.
   always_ff @(posedge clock) begin
      {head_rd_ff, tail_rd_ff} <= bkt_mem[bkt_raddr];
      if (bkt_we) begin
         bkt_mem[bkt_waddr] <= bkt_wd;
      end
   end

   // No result while the slot lists are being cleared.
   a_no_rsp_in_clear: assert property (@(posedge clock)
      state_ff == S_CLEAR |-> !rsp_valid)
      else $error("result during clearing pass");

   // A request other than a tick either reports at once or keeps the block busy.
   a_req_progress: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_opcode != OP_TICK) |=> busy || rsp_valid)
      else $error("request dropped");

   // A started timer is active when reported, a canceled one is free.
   a_started_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_kind == EV_STARTED) |-> active_ff[rsp_timer_handle[HW-1:0]])
      else $error("started timer not active");

   a_canceled_free: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_kind == EV_CANCELED) |-> !active_ff[rsp_timer_handle[HW-1:0]])
      else $error("canceled timer still active");

   // Every timer found on a slot list is active.
   a_list_active: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK_RD || state_ff == S_EXP_RD) |-> active_ff[cur_ff[HW-1:0]])
      else $error("free timer on a slot list");

endmodule
